@@ sv/clvl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clvl_pkg
// Shared types and codes for the compacting value list.
// ----------------------------------------------------------------------------
package clvl_pkg;

   localparam int ValueWidth = 32;

   typedef logic [1:0]            cmd_type;
   typedef logic [ValueWidth-1:0] value_type;

   localparam cmd_type CMD_ADD    = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_CLEAR  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_SH_RD,
      ST_SH_WR
   } state_type;

   typedef struct packed {
      logic done;
      logic ok;
      logic idle;
   } seq_status_type;

endpackage : clvl_pkg
`default_nettype wire

@@ sv/clvl_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clvl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clvl_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                    wr_data,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic      [Width-1:0]                    rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : clvl_ram
`default_nettype wire

@@ sv/clvl_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clvl_seq
// Sequencer for the list: append, clear, and a remove that scans the entry
// memory with one shared comparator and then moves later entries down.
// ----------------------------------------------------------------------------
module clvl_seq #(
   parameter int Capacity = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      start,
   input  wire clvl_pkg::cmd_type                         cmd,
   input  wire clvl_pkg::value_type                       item_value,
   input  wire clvl_pkg::value_type                       rd_data,
   output logic                                           wr_en,
   output logic [((Capacity > 1) ? $clog2(Capacity) : 1)-1:0] wr_addr,
   output clvl_pkg::value_type                            wr_data,
   output logic [((Capacity > 1) ? $clog2(Capacity) : 1)-1:0] rd_addr,
   output logic [$clog2(Capacity + 1)-1:0]                count_next,
   output clvl_pkg::seq_status_type                       status
);

   import clvl_pkg::*;

   localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int CW = $clog2(Capacity + 1);
   localparam logic [CW-1:0] CapCount = CW'(Capacity);

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;
   value_type       value_ff, value_in;
   logic [CW:0]     idx_p1, idx_p2, count_x;

   assign idx_p1  = {1'b0, idx_ff} + {{CW{1'b0}}, 1'b1};
   assign idx_p2  = {1'b0, idx_ff} + (CW+1)'(2);
   assign count_x = {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff   <= idx_in;
      value_ff <= value_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      value_in    = value_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[AW-1:0];
      wr_data     = rd_data;
      rd_addr     = idx_ff[AW-1:0];
      status.done = 1'b0;
      status.ok   = 1'b0;
      status.idle = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            status.idle = 1'b1;
            if (start) begin
               case (cmd)
                  CMD_ADD: begin
                     status.done = 1'b1;
                     if (count_ff < CapCount) begin
                        wr_en     = 1'b1;
                        wr_addr   = count_ff[AW-1:0];
                        wr_data   = item_value;
                        count_in  = count_ff + {{(CW-1){1'b0}}, 1'b1};
                        status.ok = 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        status.done = 1'b1;
                     end else begin
                        value_in = item_value;
                        idx_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in    = '0;
                     status.done = 1'b1;
                     status.ok   = 1'b1;
                  end
                  default: begin
                     status.done = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (rd_data == value_ff) begin
               if (idx_p1 < count_x) begin
                  state_in = ST_SH_RD;
               end else begin
                  count_in    = count_ff - {{(CW-1){1'b0}}, 1'b1};
                  status.done = 1'b1;
                  status.ok   = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               idx_in = idx_p1[CW-1:0];
               if (idx_p1 >= count_x) begin
                  status.done = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SH_RD: begin
            rd_addr  = idx_p1[AW-1:0];
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            idx_in  = idx_p1[CW-1:0];
            if (idx_p2 < count_x) begin
               state_in = ST_SH_RD;
            end else begin
               count_in    = count_ff - {{(CW-1){1'b0}}, 1'b1};
               status.done = 1'b1;
               status.ok   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      count_next = count_in;
   end

endmodule : clvl_seq
`default_nettype wire

@@ sv/compacting_value_list_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_value_list_top
// Fixed-capacity list of signed 32-bit values with append, remove of the
// first match (later entries move down) and clear.
// ----------------------------------------------------------------------------
// Channel  Direction  Fields
// req      in         tuser: cmd [1:0]; tdata: item_value [31:0]
// rsp      out        tdata: ok [0], entry_count [5:1], is_empty [6], zero [7]
//
// Add, clear and unused codes finish in the cycle they are taken. Remove goes
// through a scan and a compare state for each entry up to the match, then a
// shift-read and a shift-write state for each later entry moved down, set by
// the single read port of the entry RAM.
// Reset empties the list at once; the entry RAM is not cleared.
// A result waits in an output register; the next request is taken once that
// register is free or is being emptied in the same cycle.
// ----------------------------------------------------------------------------
module compacting_value_list_top #(
   parameter int CAPACITY = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [31:0] req_tdata,  // item_value [31:0]
   input  wire logic [1:0]  req_tuser,  // cmd [1:0]
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // ok, entry_count [5:1], is_empty, zero
);

   import clvl_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  rd_addr;
   value_type      wr_data;
   value_type      rd_data;
   logic [CW-1:0]  count_next;
   logic [CW+4:0]  count_wide;
   seq_status_type status;
   logic           start;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;

   assign req_tready = status.idle && (!rsp_valid_ff || rsp_tready);
   assign start      = req_tvalid && req_tready;
   assign count_wide = {5'b00000, count_next};

   clvl_ram #(
      .Width (ValueWidth),
      .Depth (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   clvl_seq #(
      .Capacity (CAPACITY)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (req_tuser),
      .item_value (req_tdata),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .count_next (count_next),
      .status     (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, (count_next == '0), count_wide[4:0], status.ok};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : compacting_value_list_top
`default_nettype wire

@@ verif/compacting_value_list_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_value_list_top_tb
// Self-checking bench for the compacting value list. A directed opening covers
// the value extremes, filling to capacity, refused appends, first-match removal
// with duplicates, misses, clears and the unused command code. Random blocks
// with a small value pool then sweep the list between empty and full. A
// scoreboard keeps its own copy of the list and compares every response in
// order. Both channels idle at random, and the response side holds off once for
// a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module compacting_value_list_top_tb;
   import clvl_pkg::*;

   localparam int      ListDepth    = 16;
   localparam int      RandomItems  = 800;
   localparam int      BlockItems   = 50;
   localparam int      PoolSize     = 6;
   localparam int      HoldOffCycles = 300;
   localparam int      DrainCycles  = 4 * ListDepth + 40;
   localparam cmd_type CMD_UNUSED   = 2'd3;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_mode_type;

   typedef struct packed {
      logic       ok;
      logic [4:0] entry_count;
      logic       is_empty;
   } list_result_type;

   class value_list_scoreboard;
      value_type       cells[ListDepth];
      int unsigned     fill_level;
      list_result_type pending_results[$];
      int              failures;
      int              requests;
      int              responses;
      int              removes_hit;
      int              adds_refused;
      int              clears;
      int              peak_level;

      function new();
         fill_level   = 0;
         failures     = 0;
         requests     = 0;
         responses    = 0;
         removes_hit  = 0;
         adds_refused = 0;
         clears       = 0;
         peak_level   = 0;
      endfunction

      function void note_request(cmd_type cmd, value_type value);
         list_result_type res;
         int              hit_index;
         hit_index = -1;
         res.ok    = 1'b0;
         case (cmd)
            CMD_ADD: begin
               if (fill_level < ListDepth) begin
                  cells[fill_level] = value;
                  fill_level++;
                  res.ok = 1'b1;
               end else begin
                  adds_refused++;
               end
            end
            CMD_REMOVE: begin
               for (int i = 0; i < fill_level; i++) begin
                  if (hit_index < 0 && cells[i] == value) begin
                     hit_index = i;
                  end
               end
               if (hit_index >= 0) begin
                  for (int j = hit_index; j + 1 < fill_level; j++) begin
                     cells[j] = cells[j + 1];
                  end
                  fill_level--;
                  res.ok = 1'b1;
                  removes_hit++;
               end
            end
            CMD_CLEAR: begin
               fill_level = 0;
               res.ok     = 1'b1;
               clears++;
            end
            default: begin
               res.ok = 1'b0;
            end
         endcase
         if (fill_level > peak_level) begin
            peak_level = fill_level;
         end
         res.entry_count = fill_level[4:0];
         res.is_empty    = (fill_level == 0);
         pending_results.push_back(res);
         requests++;
      endfunction

      function void check_response(logic [7:0] tdata);
         list_result_type got;
         list_result_type want;
         got.ok          = tdata[0];
         got.entry_count = tdata[5:1];
         got.is_empty    = tdata[6];
         responses++;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: response with nothing outstanding: ok=%0b count=%0d empty=%0b",
                        $realtime, got.ok, got.entry_count, got.is_empty);
            end
            return;
         end
         want = pending_results.pop_front();
         if (got.ok !== want.ok || got.entry_count !== want.entry_count ||
             got.is_empty !== want.is_empty) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: response %0d: want ok=%0b n=%0d e=%0b, got ok=%0b n=%0d e=%0b",
                        $realtime, responses, want.ok, want.entry_count,
                        want.is_empty, got.ok, got.entry_count, got.is_empty);
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [31:0] req_tdata = '0;   // item_value [31:0]
   logic [1:0]  req_tuser = '0;   // cmd [1:0]
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // ok [0], entry_count [5:1], is_empty [6], zero [7]

   value_list_scoreboard list_sb = new();
   bit   hold_off_request = 1'b0;
   bit   hold_off_done    = 1'b0;
   bit   quiet_sender     = 1'b0;

   compacting_value_list_top #(
      .CAPACITY(ListDepth)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            list_sb.note_request(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            list_sb.check_response(rsp_tdata);
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_sender || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(cmd_type cmd, value_type value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // The response side: random ready patterns, one long hold-off on request.
   initial begin
      int high_run;
      int low_run;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            high_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 12);
            low_run  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 3);
            rsp_tready <= 1'b1;
            repeat (high_run) @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (low_run) @(posedge clock);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("compacting_value_list_top: mismatch");
      $finish;
   end

   initial begin
      value_type    pool[PoolSize];
      mix_mode_type mode;
      int           roll;
      int           add_share;
      cmd_type      cmd;
      value_type    value;
      int           sent;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening.
      send_request(CMD_CLEAR, 32'h0000_0000);
      send_request(CMD_UNUSED, 32'hFFFF_FFFF);
      send_request(CMD_REMOVE, 32'h0000_0000);
      send_request(CMD_ADD, 32'h8000_0000);
      send_request(CMD_ADD, 32'h7FFF_FFFF);
      send_request(CMD_ADD, 32'h0000_0000);
      send_request(CMD_ADD, 32'hFFFF_FFFF);
      send_request(CMD_ADD, 32'h0000_0001);
      send_request(CMD_ADD, 32'h7FFF_FFFF);
      send_request(CMD_ADD, 32'hAAAA_AAAA);
      send_request(CMD_ADD, 32'h5555_5555);
      send_request(CMD_ADD, 32'h1234_5678);
      send_request(CMD_ADD, 32'h8000_0000);
      for (int i = 0; i < 5; i++) begin
         send_request(CMD_ADD, $urandom());
      end
      send_request(CMD_ADD, 32'h0F0F_0F0F);
      send_request(CMD_ADD, 32'h0000_0000);
      send_request(CMD_REMOVE, 32'h7FFF_FFFF);
      send_request(CMD_REMOVE, 32'h0F0F_0F0F);
      send_request(CMD_REMOVE, 32'h8000_0000);
      send_request(CMD_REMOVE, 32'hDEAD_BEEF);
      send_request(CMD_UNUSED, 32'h0000_0000);
      send_request(CMD_CLEAR, 32'hFFFF_FFFF);

      // Random blocks, each with its own value pool and add/remove balance.
      sent = 0;
      while (sent < RandomItems) begin
         if (sent == 3 * BlockItems) begin
            hold_off_request = 1'b1;
         end
         quiet_sender = ($urandom_range(0, 3) == 0);
         mode = mix_mode_type'($urandom_range(0, 2));
         case (mode)
            MIX_FILL:  add_share = 70;
            MIX_DRAIN: add_share = 25;
            default:   add_share = 48;
         endcase
         foreach (pool[k]) begin
            roll = $urandom_range(0, 9);
            case (roll)
               0:       pool[k] = 32'h8000_0000;
               1:       pool[k] = 32'h7FFF_FFFF;
               2:       pool[k] = 32'hFFFF_FFFF;
               3:       pool[k] = 32'h0000_0000;
               default: pool[k] = $urandom();
            endcase
         end
         for (int n = 0; n < BlockItems && sent < RandomItems; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               cmd = CMD_CLEAR;
            end else if (roll < 5) begin
               cmd = CMD_UNUSED;
            end else if (roll < 5 + add_share) begin
               cmd = CMD_ADD;
            end else begin
               cmd = CMD_REMOVE;
            end
            if ($urandom_range(0, 99) < 85) begin
               value = pool[$urandom_range(0, PoolSize - 1)];
            end else begin
               value = $urandom();
            end
            send_request(cmd, value);
            sent++;
         end
      end
      quiet_sender = 1'b0;
      req_tvalid <= 1'b0;

      while (list_sb.pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (list_sb.pending_results.size() != 0) begin
         $display("%0d responses never arrived", list_sb.pending_results.size());
      end
      $display("Run covered %0d requests and %0d responses; peak fill %0d of %0d.",
               list_sb.requests, list_sb.responses, list_sb.peak_level, ListDepth);
      $display("Removals that matched: %0d, appends refused when full: %0d, clears: %0d.",
               list_sb.removes_hit, list_sb.adds_refused, list_sb.clears);
      if (list_sb.failures == 0 && list_sb.pending_results.size() == 0) begin
         $display("compacting_value_list_top: match");
      end else begin
         $display("compacting_value_list_top: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/clvl_pkg.sv
sv/clvl_ram.sv
sv/clvl_seq.sv
sv/compacting_value_list_top.sv
verif/compacting_value_list_top_tb.sv
